/* rtl/ecc_pkg.sv */
// ----------------------------------------------------------------------------
// ecc_pkg: shared types, constants and calendar helpers
// Field widths, conversion constants and the month length table used by the
// epoch seconds / calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

    localparam int COUNT_W  = 32;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // serial divider: dividend and divisor widths
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 17;

    // serial multiply-accumulate: accumulator and multiplier widths
    localparam int MAC_ACC_W = 40;
    localparam int MAC_MUL_W = 17;

    // signed day count, wide enough for every year the input can name
    localparam int DAYS_W = 24;

    localparam logic [DIV_DEN_W-1:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [DIV_DEN_W-1:0] SECS_PER_HOUR   = 17'd3600;
    localparam logic [DIV_DEN_W-1:0] SECS_PER_MINUTE = 17'd60;
    localparam logic [DIV_DEN_W-1:0] SECS_PER_SECOND = 17'd1;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 12'd2000;
    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd1;

    localparam logic [8:0] DAYS_PER_YEAR      = 9'd365;
    localparam logic [8:0] DAYS_PER_LEAP_YEAR = 9'd366;

    typedef logic signed [DAYS_W-1:0] t_days;

    typedef struct packed {
        logic                cmd;
        logic [COUNT_W-1:0]  count_in;
        logic [YEAR_W-1:0]   year_in;
        logic [MONTH_W-1:0]  month_in;
        logic [DAY_W-1:0]    day_in;
        logic [HOUR_W-1:0]   hour_in;
        logic [MINUTE_W-1:0] minute_in;
        logic [SECOND_W-1:0] second_in;
    } t_cvt_req;

    typedef struct packed {
        logic [COUNT_W-1:0]  count_out;
        logic [YEAR_W-1:0]   year_out;
        logic [MONTH_W-1:0]  month_out;
        logic [DAY_W-1:0]    day_out;
        logic [HOUR_W-1:0]   hour_out;
        logic [MINUTE_W-1:0] minute_out;
        logic [SECOND_W-1:0] second_out;
        logic                overflow;
    } t_cvt_rsp;

    // command codes
    localparam logic CMD_TO_DATE  = 1'b0;
    localparam logic CMD_TO_COUNT = 1'b1;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            FEBRUARY: d = leap ? 5'd29 : 5'd28;
            4'd3:     d = 5'd30;
            4'd5:     d = 5'd30;
            4'd8:     d = 5'd30;
            4'd10:    d = 5'd30;
            default:  d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/ecc_if.sv */
// ----------------------------------------------------------------------------
// ecc_if: request and response channels
// Valid/ready channels carrying one conversion request or one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecc_req_if;
    logic              valid;
    logic              ready;
    ecc_pkg::t_cvt_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ecc_rsp_if;
    logic              valid;
    logic              ready;
    ecc_pkg::t_cvt_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/ecc_sdiv.sv */
// ----------------------------------------------------------------------------
// ecc_sdiv: bit-serial restoring divider
// One quotient bit per cycle; quotient and remainder are valid once busy
// drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_sdiv #(
    parameter int P_NUM_W = ecc_pkg::DIV_NUM_W,
    parameter int P_DEN_W = ecc_pkg::DIV_DEN_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [P_NUM_W-1:0] i_num,
    input  wire logic [P_DEN_W-1:0] i_den,
    output logic                    o_busy,
    output logic      [P_NUM_W-1:0] o_quo,
    output logic      [P_DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(P_NUM_W + 1);

    logic [P_NUM_W-1:0] r_q;
    logic [P_DEN_W-1:0] r_r;
    logic [P_DEN_W-1:0] r_den;
    logic [CNT_W-1:0]   r_cnt;

    logic [P_DEN_W:0]   n_trial;
    logic [P_DEN_W:0]   n_diff;
    logic               n_ge;

    assign n_trial = {r_r, r_q[P_NUM_W-1]};
    assign n_diff  = n_trial - {1'b0, r_den};
    assign n_ge    = (n_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_q   <= i_num;
            r_r   <= '0;
            r_den <= i_den;
            r_cnt <= CNT_W'(P_NUM_W);
        end else if (o_busy) begin
            // shift in the next dividend bit, subtract where it fits
            r_r   <= n_ge ? n_diff[P_DEN_W-1:0] : n_trial[P_DEN_W-1:0];
            r_q   <= {r_q[P_NUM_W-2:0], n_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
    assign o_rem  = r_r;

endmodule

`default_nettype wire

/* rtl/ecc_smac.sv */
// ----------------------------------------------------------------------------
// ecc_smac: bit-serial multiply-accumulate
// Adds a signed multiplicand times an unsigned multiplier into the
// accumulator, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_smac #(
    parameter int P_ACC_W = ecc_pkg::MAC_ACC_W,
    parameter int P_MUL_W = ecc_pkg::MAC_MUL_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_clr,
    input  wire logic [P_ACC_W-1:0] i_a,
    input  wire logic [P_MUL_W-1:0] i_b,
    output logic                    o_busy,
    output logic      [P_ACC_W-1:0] o_acc
);

    logic [P_ACC_W-1:0] r_a;
    logic [P_MUL_W-1:0] r_b;
    logic [P_ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
        end else if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            if (i_clr) begin
                r_acc <= '0;
            end
        end else if (o_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[P_ACC_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[P_MUL_W-1:1]};
        end
    end

    // done as soon as no multiplier bits remain
    assign o_busy = (r_b != '0);
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

/* rtl/ecc_cal.sv */
// ----------------------------------------------------------------------------
// ecc_cal: year counter with leap rule
// Counts years from the epoch and tracks the year modulo 100 and 400 so
// the leap flag needs no division.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_cal (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_init,
    input  wire logic                        i_step,
    output logic [ecc_pkg::YEAR_W-1:0]       o_year,
    output logic                             o_leap
);

    localparam logic [6:0] C100_LAST = 7'd99;
    localparam logic [8:0] C400_LAST = 9'd399;

    logic [ecc_pkg::YEAR_W-1:0] r_year;
    logic [6:0]                 r_c100;
    logic [8:0]                 r_c400;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            // the epoch year is a multiple of 400
            r_year <= ecc_pkg::EPOCH_YEAR;
            r_c100 <= '0;
            r_c400 <= '0;
        end else if (i_step) begin
            r_year <= r_year + ecc_pkg::YEAR_W'(1);
            r_c100 <= (r_c100 == C100_LAST) ? 7'd0 : r_c100 + 7'd1;
            r_c400 <= (r_c400 == C400_LAST) ? 9'd0 : r_c400 + 9'd1;
        end
    end

    assign o_year = r_year;
    assign o_leap = (r_c400 == 9'd0) || ((r_c100 != 7'd0) && (r_year[1:0] == 2'd0));

endmodule

`default_nettype wire

/* rtl/epoch_seconds_calendar_convert_unit.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_convert_unit: seconds count <-> calendar date
// Converts seconds since 2000-01-01 00:00:00 to a Gregorian date and time
// (cmd 0) or a date and time to seconds with an overflow flag (cmd 1).
// ----------------------------------------------------------------------------
//  channel   | dir | handshake        | payload
//  i_req     | in  | valid / ready    | cmd, count_in, year..second_in
//  o_rsp     | out | valid / ready    | count_out, year..second_out, overflow
//
//  cmd 0: three passes of the bit-serial divider (days, hours, minutes), then
//         a year walk over the years past 2000 and a month walk.
//  cmd 1: after clamping, the one-year-per-cycle walk up to year_in, then the
//         month walk and four multiply-accumulate passes.
//  One transaction at a time; i_req.ready is high only while idle, and a held
//  result stalls only the finish of the next. Sync reset clears o_rsp.valid.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_calendar_convert_unit (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ecc_req_if.sink       i_req,
    ecc_rsp_if.source     o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_DAY,
        S_DIV_HOUR,
        S_DIV_MIN,
        S_YEAR,
        S_MONTH,
        S_MAC_LOAD,
        S_MAC_RUN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        T_DAYS,
        T_HOURS,
        T_MINUTES,
        T_SECONDS
    } t_term;

    t_state                              r_state;
    t_term                               r_term;
    logic                                r_cmd;
    logic [ecc_pkg::YEAR_W-1:0]          r_year_tgt;
    logic [ecc_pkg::MONTH_W-1:0]         r_mon_tgt;
    logic [ecc_pkg::DAY_W-1:0]           r_day_in;
    logic [ecc_pkg::MONTH_W-1:0]         r_mon;
    ecc_pkg::t_days                      r_days;
    logic [ecc_pkg::HOUR_W-1:0]          r_hour;
    logic [ecc_pkg::MINUTE_W-1:0]        r_min;
    logic [ecc_pkg::SECOND_W-1:0]        r_sec;
    logic                                r_out_valid;
    ecc_pkg::t_cvt_rsp                   r_out;

    logic                                n_accept;
    logic                                n_done;
    ecc_pkg::t_cvt_rsp                   n_out;
    logic                                div_start;
    logic [ecc_pkg::DIV_NUM_W-1:0]       div_num;
    logic [ecc_pkg::DIV_DEN_W-1:0]       div_den;
    logic                                div_busy;
    logic [ecc_pkg::DIV_NUM_W-1:0]       div_quo;
    logic [ecc_pkg::DIV_DEN_W-1:0]       div_rem;

    logic                                mac_start;
    logic                                mac_clr;
    logic [ecc_pkg::MAC_ACC_W-1:0]       mac_a;
    logic [ecc_pkg::MAC_MUL_W-1:0]       mac_b;
    logic                                mac_busy;
    logic [ecc_pkg::MAC_ACC_W-1:0]       mac_acc;

    logic                                cal_init;
    logic                                cal_step;
    logic [ecc_pkg::YEAR_W-1:0]          cal_year;
    logic                                cal_leap;

    ecc_pkg::t_days                      n_ylen;
    ecc_pkg::t_days                      n_mlen;

    assign n_accept = i_req.valid && i_req.ready;
    assign n_done   = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign n_ylen   = ecc_pkg::t_days'(cal_leap ? ecc_pkg::DAYS_PER_LEAP_YEAR
                                                : ecc_pkg::DAYS_PER_YEAR);
    assign n_mlen   = ecc_pkg::t_days'(ecc_pkg::month_len(r_mon, cal_leap));

    ecc_sdiv #(
        .P_NUM_W (ecc_pkg::DIV_NUM_W),
        .P_DEN_W (ecc_pkg::DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    ecc_smac #(
        .P_ACC_W (ecc_pkg::MAC_ACC_W),
        .P_MUL_W (ecc_pkg::MAC_MUL_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_clr   (mac_clr),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    ecc_cal u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (cal_init),
        .i_step  (cal_step),
        .o_year  (cal_year),
        .o_leap  (cal_leap)
    );

    always_comb begin
        div_start = 1'b0;
        div_num   = i_req.data.count_in;
        div_den   = ecc_pkg::SECS_PER_DAY;
        mac_start = 1'b0;
        mac_clr   = 1'b0;
        mac_a     = ecc_pkg::MAC_ACC_W'(r_days);
        mac_b     = ecc_pkg::SECS_PER_DAY;
        cal_init  = 1'b0;
        cal_step  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (n_accept) begin
                    cal_init  = 1'b1;
                    div_start = (i_req.data.cmd == ecc_pkg::CMD_TO_DATE);
                end
            end
            S_DIV_DAY: begin
                div_start = !div_busy;
                div_num   = ecc_pkg::DIV_NUM_W'(div_rem);
                div_den   = ecc_pkg::SECS_PER_HOUR;
            end
            S_DIV_HOUR: begin
                div_start = !div_busy;
                div_num   = ecc_pkg::DIV_NUM_W'(div_rem);
                div_den   = ecc_pkg::SECS_PER_MINUTE;
            end
            S_YEAR: begin
                if (r_cmd == ecc_pkg::CMD_TO_DATE) begin
                    cal_step = (r_days >= n_ylen);
                end else begin
                    cal_step = (cal_year != r_year_tgt);
                end
            end
            S_MAC_LOAD: begin
                mac_start = 1'b1;
                mac_clr   = (r_term == T_DAYS);
                unique case (r_term)
                    T_DAYS: begin
                        mac_a = ecc_pkg::MAC_ACC_W'(r_days);
                        mac_b = ecc_pkg::SECS_PER_DAY;
                    end
                    T_HOURS: begin
                        mac_a = ecc_pkg::MAC_ACC_W'(r_hour);
                        mac_b = ecc_pkg::SECS_PER_HOUR;
                    end
                    T_MINUTES: begin
                        mac_a = ecc_pkg::MAC_ACC_W'(r_min);
                        mac_b = ecc_pkg::SECS_PER_MINUTE;
                    end
                    T_SECONDS: begin
                        mac_a = ecc_pkg::MAC_ACC_W'(r_sec);
                        mac_b = ecc_pkg::SECS_PER_SECOND;
                    end
                    default: begin
                        mac_a = '0;
                        mac_b = '0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // result word for the finished conversion; unused fields stay zero
    always_comb begin
        n_out = '0;
        if (r_cmd == ecc_pkg::CMD_TO_DATE) begin
            n_out.year_out   = cal_year;
            n_out.month_out  = r_mon;
            n_out.day_out    = r_days[ecc_pkg::DAY_W-1:0] + ecc_pkg::DAY_W'(1);
            n_out.hour_out   = r_hour;
            n_out.minute_out = r_min;
            n_out.second_out = r_sec;
        end else begin
            n_out.count_out  = mac_acc[ecc_pkg::COUNT_W-1:0];
            n_out.overflow   = |mac_acc[ecc_pkg::MAC_ACC_W-1:ecc_pkg::COUNT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (n_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_cmd      <= i_req.data.cmd;
                        r_year_tgt <= (i_req.data.year_in < ecc_pkg::EPOCH_YEAR)
                                      ? ecc_pkg::EPOCH_YEAR : i_req.data.year_in;
                        r_mon_tgt  <= (i_req.data.month_in > ecc_pkg::LAST_MONTH)
                                      ? ecc_pkg::LAST_MONTH : i_req.data.month_in;
                        r_day_in   <= i_req.data.day_in;
                        r_hour     <= i_req.data.hour_in;
                        r_min      <= i_req.data.minute_in;
                        r_sec      <= i_req.data.second_in;
                        r_days     <= '0;
                        r_mon      <= '0;
                        r_state    <= (i_req.data.cmd == ecc_pkg::CMD_TO_DATE)
                                      ? S_DIV_DAY : S_YEAR;
                    end
                end
                S_DIV_DAY: begin
                    if (!div_busy) begin
                        r_days  <= ecc_pkg::t_days'(div_quo[ecc_pkg::DAYS_W-1:0]);
                        r_state <= S_DIV_HOUR;
                    end
                end
                S_DIV_HOUR: begin
                    if (!div_busy) begin
                        r_hour  <= div_quo[ecc_pkg::HOUR_W-1:0];
                        r_state <= S_DIV_MIN;
                    end
                end
                S_DIV_MIN: begin
                    if (!div_busy) begin
                        r_min   <= div_quo[ecc_pkg::MINUTE_W-1:0];
                        r_sec   <= div_rem[ecc_pkg::SECOND_W-1:0];
                        r_state <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    // one year per cycle; the year counter advances alongside
                    if (r_cmd == ecc_pkg::CMD_TO_DATE) begin
                        if (r_days >= n_ylen) begin
                            r_days <= r_days - n_ylen;
                        end else begin
                            r_state <= S_MONTH;
                        end
                    end else begin
                        if (cal_year != r_year_tgt) begin
                            r_days <= r_days + n_ylen;
                        end else begin
                            r_state <= S_MONTH;
                        end
                    end
                end
                S_MONTH: begin
                    if (r_cmd == ecc_pkg::CMD_TO_DATE) begin
                        if ((r_mon < ecc_pkg::LAST_MONTH) && (r_days >= n_mlen)) begin
                            r_days <= r_days - n_mlen;
                            r_mon  <= r_mon + ecc_pkg::MONTH_W'(1);
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        if (r_mon < r_mon_tgt) begin
                            r_days <= r_days + n_mlen;
                            r_mon  <= r_mon + ecc_pkg::MONTH_W'(1);
                        end else begin
                            // day offset is taken as it stands, zero rolls back
                            r_days  <= r_days + ecc_pkg::t_days'(r_day_in)
                                       - ecc_pkg::t_days'(1);
                            r_term  <= T_DAYS;
                            r_state <= S_MAC_LOAD;
                        end
                    end
                end
                S_MAC_LOAD: begin
                    r_state <= S_MAC_RUN;
                end
                S_MAC_RUN: begin
                    if (!mac_busy) begin
                        if (r_term == T_SECONDS) begin
                            r_state <= S_DONE;
                        end else begin
                            r_term  <= t_term'(r_term + 2'd1);
                            r_state <= S_MAC_LOAD;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (n_done) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

/* rtl/ecc_chk.sv */
// ----------------------------------------------------------------------------
// ecc_chk: port-level checks for the calendar converter
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_chk (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire ecc_pkg::t_cvt_rsp i_rsp_data
);

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled response changed");

    // one transaction at a time: busy after an accepted request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while busy");

    // a date result carries no count and no overflow
    a_date_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_data.year_out != '0) |->
            (i_rsp_data.count_out == '0) && !i_rsp_data.overflow)
        else $error("date result with count fields set");

    // a date result stays in calendar range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_data.year_out != '0) |->
            (i_rsp_data.month_out <= 4'd11) && (i_rsp_data.day_out != '0) &&
            (i_rsp_data.hour_out <= 5'd23) && (i_rsp_data.minute_out <= 6'd59) &&
            (i_rsp_data.second_out <= 6'd59))
        else $error("date result out of range");

endmodule

bind epoch_seconds_calendar_convert_unit ecc_chk u_ecc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for epoch_seconds_calendar_convert_unit
// Drives conversion requests in both directions over the valid/ready request
// channel and compares every result against a behavioral calendar model.
// Directed edge cases come first, then random traffic under several pacing
// phases, including a long output hold-off that backs up the request side.
// ----------------------------------------------------------------------------

module tb;

    typedef enum logic [2:0] {
        PH_DIRECTED,
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH,
        PH_BACKPRESSURE
    } t_pacing;

    localparam int unsigned LONG_HOLD_CYCLES = 3000;
    localparam int unsigned ITEMS_PER_PHASE  = 330;
    localparam int unsigned BACKPRESSURE_ITEMS = 30;
    localparam int unsigned DRAIN_CYCLES     = 300;

    logic i_clk;
    logic i_rst_n;

    ecc_req_if req_if ();
    ecc_rsp_if rsp_if ();

    epoch_seconds_calendar_convert_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    ecc_pkg::t_cvt_req pending_reqs[$];
    ecc_pkg::t_cvt_rsp expected_results[$];
    t_pacing     phase = PH_DIRECTED;
    logic        req_taken = 1'b0;
    int unsigned long_hold_cycles = 0;
    int unsigned mismatch_count = 0;
    int unsigned date_results = 0;
    int unsigned count_results = 0;
    int unsigned overflow_results = 0;

    // ------------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------------
    function automatic bit leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        int unsigned d;
        case (m)
            1:       d = leap_year(y) ? 29 : 28;
            3, 5, 8, 10: d = 30;
            default: d = 31;
        endcase
        return d;
    endfunction

    function automatic ecc_pkg::t_cvt_rsp predict_conversion(ecc_pkg::t_cvt_req req);
        ecc_pkg::t_cvt_rsp rsp;
        int unsigned days;
        int unsigned rem;
        int unsigned y;
        int unsigned m;
        int unsigned k;
        longint      day_count;
        longint      total;
        rsp = '0;
        if (req.cmd == ecc_pkg::CMD_TO_DATE) begin
            days = req.count_in / 32'd86400;
            rem  = req.count_in % 32'd86400;
            y    = 2000;
            m    = 0;
            while (days >= (leap_year(y) ? 366 : 365)) begin
                days -= leap_year(y) ? 366 : 365;
                y++;
            end
            while (m < 11 && days >= days_in_month(y, m)) begin
                days -= days_in_month(y, m);
                m++;
            end
            rsp.year_out   = y[ecc_pkg::YEAR_W-1:0];
            rsp.month_out  = m[ecc_pkg::MONTH_W-1:0];
            rsp.day_out    = ecc_pkg::DAY_W'(days + 1);
            rsp.hour_out   = ecc_pkg::HOUR_W'(rem / 3600);
            rsp.minute_out = ecc_pkg::MINUTE_W'((rem / 60) % 60);
            rsp.second_out = ecc_pkg::SECOND_W'(rem % 60);
        end else begin
            // clamp year to the epoch and month to December
            y = (req.year_in < 2000) ? 2000 : req.year_in;
            m = (req.month_in > 11) ? 11 : req.month_in;
            day_count = 0;
            for (k = 2000; k < y; k++)
                day_count += leap_year(k) ? 366 : 365;
            for (k = 0; k < m; k++)
                day_count += days_in_month(y, k);
            day_count += longint'(req.day_in) - 1;
            total = day_count * 86400
                  + longint'(req.hour_in) * 3600
                  + longint'(req.minute_in) * 60
                  + longint'(req.second_in);
            rsp.count_out = total[31:0];
            rsp.overflow  = (total < 0) || (total > longint'(32'hFFFF_FFFF));
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    function automatic ecc_pkg::t_cvt_req date_request(int unsigned y, int unsigned m,
                                                       int unsigned d, int unsigned h,
                                                       int unsigned mi, int unsigned s);
        ecc_pkg::t_cvt_req r;
        r           = '0;
        r.cmd       = ecc_pkg::CMD_TO_COUNT;
        r.year_in   = ecc_pkg::YEAR_W'(y);
        r.month_in  = ecc_pkg::MONTH_W'(m);
        r.day_in    = ecc_pkg::DAY_W'(d);
        r.hour_in   = ecc_pkg::HOUR_W'(h);
        r.minute_in = ecc_pkg::MINUTE_W'(mi);
        r.second_in = ecc_pkg::SECOND_W'(s);
        return r;
    endfunction

    function automatic ecc_pkg::t_cvt_req count_request(logic [ecc_pkg::COUNT_W-1:0] c);
        ecc_pkg::t_cvt_req r;
        r          = '0;
        r.cmd      = ecc_pkg::CMD_TO_DATE;
        r.count_in = c;
        return r;
    endfunction

    // seconds count of a date, for round trips through the to-date direction
    function automatic ecc_pkg::t_cvt_req round_trip(int unsigned y, int unsigned m,
                                                     int unsigned d, int unsigned h,
                                                     int unsigned mi, int unsigned s);
        ecc_pkg::t_cvt_rsp rsp;
        rsp = predict_conversion(date_request(y, m, d, h, mi, s));
        return count_request(rsp.count_out);
    endfunction

    function automatic ecc_pkg::t_cvt_req random_request();
        ecc_pkg::t_cvt_req r;
        int unsigned pick;
        int unsigned y;
        int unsigned m;
        r.cmd       = 1'($urandom_range(0, 1));
        r.count_in  = $urandom;
        r.year_in   = ecc_pkg::YEAR_W'($urandom);
        r.month_in  = ecc_pkg::MONTH_W'($urandom);
        r.day_in    = ecc_pkg::DAY_W'($urandom);
        r.hour_in   = ecc_pkg::HOUR_W'($urandom);
        r.minute_in = ecc_pkg::MINUTE_W'($urandom);
        r.second_in = ecc_pkg::SECOND_W'($urandom);
        if (r.cmd == ecc_pkg::CMD_TO_DATE) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                r.count_in = $urandom;
            else if (pick < 85)
                r.count_in = $urandom_range(0, 86400 * 800);
            else if (pick < 95)
                r.count_in = 32'hFFFF_FFFF - $urandom_range(0, 86400 * 400);
            else
                r.count_in = $urandom_range(0, 49709) * 86400
                           + ($urandom_range(0, 1) ? 86399 : 0);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                y = $urandom_range(2000, 2136);
            else if (pick < 92)
                y = $urandom_range(2130, 2136);
            else if (pick < 97)
                y = $urandom_range(0, 1999);
            else
                y = $urandom_range(2137, 4095);
            m = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 11)
                                             : $urandom_range(12, 15);
            r.year_in  = ecc_pkg::YEAR_W'(y);
            r.month_in = ecc_pkg::MONTH_W'(m);
            if ($urandom_range(0, 99) < 80)
                r.day_in = ecc_pkg::DAY_W'($urandom_range(1,
                    days_in_month((y < 2000) ? 2000 : y, (m > 11) ? 11 : m)));
            else
                r.day_in = ecc_pkg::DAY_W'($urandom_range(0, 31));
            r.hour_in   = ecc_pkg::HOUR_W'(($urandom_range(0, 99) < 92) ?
                          $urandom_range(0, 23) : $urandom_range(24, 31));
            r.minute_in = ecc_pkg::MINUTE_W'(($urandom_range(0, 99) < 92) ?
                          $urandom_range(0, 59) : $urandom_range(60, 63));
            r.second_in = ecc_pkg::SECOND_W'(($urandom_range(0, 99) < 92) ?
                          $urandom_range(0, 59) : $urandom_range(60, 63));
        end
        return r;
    endfunction

    function automatic int unsigned sender_idle_pct();
        case (phase)
            PH_SRC_IDLE: return 48;
            PH_BOTH:     return 35;
            default:     return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct();
        case (phase)
            PH_SNK_STALL: return 48;
            PH_BOTH:      return 35;
            default:      return 0;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Request driver: hold the transaction until taken, then offer the next
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                req_if.data  <= pending_reqs.pop_front();
                req_if.valid <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response ready: random stalls, plus one long hold-off under backpressure
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (phase == PH_BACKPRESSURE && long_hold_cycles < LONG_HOLD_CYCLES) begin
            long_hold_cycles <= long_hold_cycles + 1;
            rsp_if.ready     <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on request accept, compare on response accept
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        ecc_pkg::t_cvt_rsp want;
        ecc_pkg::t_cvt_rsp got;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready)
                expected_results.push_back(predict_conversion(req_if.data));
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no pending request");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("count_out",  want.count_out,  got.count_out);
                    check_field("year_out",   want.year_out,   got.year_out);
                    check_field("month_out",  want.month_out,  got.month_out);
                    check_field("day_out",    want.day_out,    got.day_out);
                    check_field("hour_out",   want.hour_out,   got.hour_out);
                    check_field("minute_out", want.minute_out, got.minute_out);
                    check_field("second_out", want.second_out, got.second_out);
                    check_field("overflow",   want.overflow,   got.overflow);
                    if (want.year_out != 0)
                        date_results++;
                    else
                        count_results++;
                    if (want.overflow)
                        overflow_results++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic wait_all_done();
        while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random_phase(t_pacing p, int unsigned n);
        phase = p;
        repeat (n) pending_reqs.push_back(random_request());
        wait_all_done();
    endtask

    initial begin : stimulus
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // seconds to date: epoch, top of range, day boundaries
        pending_reqs.push_back(count_request(32'd0));
        pending_reqs.push_back(count_request(32'hFFFF_FFFF));
        pending_reqs.push_back(count_request(32'd86399));
        pending_reqs.push_back(count_request(32'd86400));
        // leap and century transitions, through the to-date direction
        pending_reqs.push_back(round_trip(2000, 1, 29, 12, 34, 56));
        pending_reqs.push_back(round_trip(2000, 11, 31, 23, 59, 59));
        pending_reqs.push_back(round_trip(2100, 1, 28, 23, 59, 59));
        pending_reqs.push_back(round_trip(2100, 2, 1, 0, 0, 0));
        pending_reqs.push_back(round_trip(2004, 1, 29, 0, 0, 0));
        // date to seconds: epoch, last representable second, first overflow
        pending_reqs.push_back(date_request(2000, 0, 1, 0, 0, 0));
        pending_reqs.push_back(date_request(2136, 1, 7, 6, 28, 15));
        pending_reqs.push_back(date_request(2136, 1, 7, 6, 28, 16));
        // year before epoch clamps to the epoch year
        pending_reqs.push_back(date_request(0, 0, 1, 0, 0, 0));
        pending_reqs.push_back(date_request(1999, 5, 15, 8, 30, 0));
        // every field at its bit maximum
        pending_reqs.push_back(date_request(4095, 15, 31, 31, 63, 63));
        // day zero at the epoch goes negative and wraps
        pending_reqs.push_back(date_request(2000, 0, 0, 0, 0, 0));
        // month past December clamps to December
        pending_reqs.push_back(date_request(2024, 12, 1, 0, 0, 0));
        pending_reqs.push_back(date_request(2024, 15, 31, 23, 59, 59));
        // day past the end of the month rolls forward
        pending_reqs.push_back(date_request(2001, 1, 31, 0, 0, 0));
        pending_reqs.push_back(date_request(2100, 1, 29, 0, 0, 0));
        pending_reqs.push_back(date_request(2096, 1, 29, 12, 0, 0));
        // time of day beyond range adds as it stands
        pending_reqs.push_back(date_request(2000, 0, 1, 31, 63, 63));
        pending_reqs.push_back(date_request(2000, 0, 31, 23, 59, 59));
        wait_all_done();

        run_random_phase(PH_FREE,      ITEMS_PER_PHASE);
        run_random_phase(PH_SRC_IDLE,  ITEMS_PER_PHASE);
        run_random_phase(PH_SNK_STALL, ITEMS_PER_PHASE);
        run_random_phase(PH_BOTH,      ITEMS_PER_PHASE);
        run_random_phase(PH_BACKPRESSURE, BACKPRESSURE_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d to-date and %0d to-seconds conversions (%0d overflowed)",
                 date_results, count_results, overflow_results);
        $display("Pacing: free-running, sender idle, receiver stall, both, long hold-off");
        if (mismatch_count == 0) begin
            $display("PASS epoch_seconds_calendar_convert_unit");
        end else begin
            $display("FAIL epoch_seconds_calendar_convert_unit");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        #200ms;
        $display("FAIL epoch_seconds_calendar_convert_unit");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ecc_pkg.sv
rtl/ecc_if.sv
rtl/ecc_sdiv.sv
rtl/ecc_smac.sv
rtl/ecc_cal.sv
rtl/epoch_seconds_calendar_convert_unit.sv
rtl/ecc_chk.sv
tb/tb.sv
